/* sv/irdla_pkg.sv */
`timescale 1ns / 1ps

package irdla_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int DEF_WINDOW      = 5;
    localparam int DEF_CHANNELS    = 4;
    localparam int DEF_SAMPLE_BITS = 8;

    // Fixed-point formats.
    localparam int COEF_W       = 32;  // signed coefficient, 24 fraction bits
    localparam int ACC_W        = 40;  // polynomial accumulator, kept modulo 2^40
    localparam int ENTRY_W      = 32;  // stored window entry, 16 fraction bits
    localparam int FRAC_DROP    = 8;   // 24 - 16 fraction bits dropped by floor
    localparam int ENTRY_FRAC   = 16;
    localparam int SCALE_FACTOR = 10;
    localparam int TERMS        = 4;

    // Reciprocal for the constant divide by the window length.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // Configuration port.
    localparam int CFG_W      = 8;
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_UPPER_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_UPPER_VALUE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOWER_LIMIT = 2'd2;

    localparam logic [CFG_W-1:0] UPPER_LIMIT_RST = 8'd230;
    localparam logic [CFG_W-1:0] UPPER_VALUE_RST = 8'd245;
    localparam logic [CFG_W-1:0] LOWER_LIMIT_RST = 8'd40;

    // Operation of the shared multiply-accumulate unit.
    typedef enum logic [1:0] {
        POLY_HOLD,
        POLY_LOAD,
        POLY_MAC
    } poly_op_t;

    typedef struct packed {
        poly_op_t          op;
        logic [COEF_W-1:0] coef;
    } poly_ctrl_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_SCALE,
        ST_WRITE,
        ST_AVG_MUL,
        ST_AVG_FIX,
        ST_OUT
    } state_t;

    // Cubic coefficients per channel row, term 0 is the cubic term.
    function automatic logic [COEF_W-1:0] coef_at(input logic [1:0] row,
                                                  input logic [1:0] term);
        logic [COEF_W-1:0] c;
        case ({row, term})
            4'b00_00: c = -32'sd366;
            4'b00_01: c =  32'sd109052;
            4'b00_10: c = -32'sd12124894;
            4'b00_11: c =  32'sd587470995;
            4'b01_00: c = -32'sd466;
            4'b01_01: c =  32'sd129185;
            4'b01_10: c = -32'sd13347953;
            4'b01_11: c =  32'sd601233346;
            4'b10_00: c = -32'sd433;
            4'b10_01: c =  32'sd129185;
            4'b10_10: c = -32'sd13913345;
            4'b10_11: c =  32'sd634490821;
            4'b11_00: c = -32'sd400;
            4'b11_01: c =  32'sd119118;
            4'b11_10: c = -32'sd13186892;
            4'b11_11: c =  32'sd621637796;
            default:  c = '0;
        endcase
        return c;
    endfunction

endpackage

/* sv/ir_distance_linearize_average.sv */
`timescale 1ns / 1ps

// Four-channel IR distance linearizer with a moving average. Each input word
// carries one raw sample per channel; each sample is turned into ten times a
// distance by its channel's cubic polynomial (coefficients with 24 fraction
// bits, result kept with 16 fraction bits), written into a window of the last
// WINDOW conversions, and each channel's window average is clamped against
// the limit registers. One output word follows each input word. The block
// takes one word at a time and accepts no new word until its result is in
// the output register. The single multiply-accumulate unit runs five steps
// of Horner evaluation and one window update per channel; the divide and
// clamp for each channel follow, and then the output register is loaded. A
// result still waiting at the output holds the block until it is taken.
// The window starts empty after reset and needs no clearing pass.
// Configuration registers may be written at any time the block is idle.
module ir_distance_linearize_average #(
    parameter int WINDOW      = irdla_pkg::DEF_WINDOW,
    parameter int CHANNELS    = irdla_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS = irdla_pkg::DEF_SAMPLE_BITS,
    localparam int IN_W  = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = CHANNELS * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields, low bits first: sample_right_front, sample_right_rear,
    // sample_left_front, sample_left_rear.
    input  logic [IN_W-1:0]                 s_tdata,

    // Output stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields, low bits first: dist_right_front, dist_right_rear,
    // dist_left_front, dist_left_rear.
    output logic [OUT_W-1:0]                m_tdata,

    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [irdla_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [irdla_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int ACC_W   = irdla_pkg::ACC_W;
    localparam int ENTRY_W = irdla_pkg::ENTRY_W;
    localparam int DEPTH   = WINDOW * CHANNELS;
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W   = ENTRY_W + 1 + $clog2(WINDOW);
    localparam int T_W     = SUM_W - irdla_pkg::ENTRY_FRAC;
    localparam int RECIP_W = irdla_pkg::RECIP_W;
    localparam int PROD_W  = T_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((1 << irdla_pkg::RECIP_SHIFT) / WINDOW);

    // Control state.
    irdla_pkg::state_t state_reg, state_next;
    logic [CH_W-1:0]   ch_reg;
    logic [1:0]        term_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [WINDOW-1:0] slot_valid_reg;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;

    // Configuration registers.
    logic [7:0] upper_limit_reg;
    logic [7:0] upper_value_reg;
    logic [7:0] lower_limit_reg;

    // Data path.
    logic [SAMPLE_BITS-1:0] sample_reg [CHANNELS];
    logic [SUM_W-1:0]       sum_reg [CHANNELS];
    logic [7:0]             res_reg [CHANNELS];
    logic [PROD_W-1:0]      prod_reg;
    logic [OUT_W-1:0]       m_tdata_reg;

    logic                   s_accept;
    logic                   last_ch;
    logic                   last_term;
    logic                   out_free;
    logic [1:0]             coef_row;
    logic [ADDR_W-1:0]      win_addr;
    logic                   ram_we;
    logic                   ram_re;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [ENTRY_W-1:0]     new_entry;
    logic [ENTRY_W-1:0]     old_entry;
    logic [SUM_W-1:0]       sum_upd;
    logic [T_W-1:0]         t_val;
    logic [T_W-1:0]         q_est;
    logic [T_W-1:0]         q_rem;
    logic [T_W-1:0]         q_val;
    logic [7:0]             clamp_val;
    logic [ACC_W-1:0]       acc;
    irdla_pkg::poly_ctrl_t  poly_ctrl;
    logic [SAMPLE_BITS-1:0] poly_oper;

    assign s_accept  = s_tvalid && s_tready;
    assign last_ch   = (ch_reg == CH_W'(CHANNELS - 1));
    assign last_term = (term_reg == 2'(irdla_pkg::TERMS - 1));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign coef_row  = 2'(ch_reg % 4);
    assign win_addr  = ADDR_W'(slot_reg) * ADDR_W'(CHANNELS) + ADDR_W'(ch_reg);

    // Output valid: set when a new word is loaded, cleared when taken.
    assign m_tvalid_next = (state_reg == irdla_pkg::ST_OUT && out_free) ? 1'b1 :
                           (m_tready ? 1'b0 : m_tvalid_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            irdla_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = irdla_pkg::ST_LOAD;
            end
            irdla_pkg::ST_LOAD:  state_next = irdla_pkg::ST_MAC;
            irdla_pkg::ST_MAC: begin
                if (last_term) state_next = irdla_pkg::ST_SCALE;
            end
            irdla_pkg::ST_SCALE: state_next = irdla_pkg::ST_WRITE;
            irdla_pkg::ST_WRITE: begin
                state_next = last_ch ? irdla_pkg::ST_AVG_MUL : irdla_pkg::ST_LOAD;
            end
            irdla_pkg::ST_AVG_MUL: state_next = irdla_pkg::ST_AVG_FIX;
            irdla_pkg::ST_AVG_FIX: begin
                state_next = last_ch ? irdla_pkg::ST_OUT : irdla_pkg::ST_AVG_MUL;
            end
            irdla_pkg::ST_OUT: begin
                if (out_free) state_next = irdla_pkg::ST_IDLE;
            end
            default: state_next = irdla_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: ready, unit control and window port.
    always_comb begin
        s_tready       = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        poly_ctrl.op   = irdla_pkg::POLY_HOLD;
        poly_ctrl.coef = '0;
        poly_oper      = sample_reg[ch_reg];
        case (state_reg)
            irdla_pkg::ST_IDLE: s_tready = 1'b1;
            irdla_pkg::ST_LOAD: begin
                ram_re         = 1'b1;
                poly_ctrl.op   = irdla_pkg::POLY_LOAD;
                poly_ctrl.coef = irdla_pkg::coef_at(coef_row, 2'd0);
            end
            irdla_pkg::ST_MAC: begin
                poly_ctrl.op   = irdla_pkg::POLY_MAC;
                poly_ctrl.coef = irdla_pkg::coef_at(coef_row, term_reg);
            end
            irdla_pkg::ST_SCALE: begin
                poly_ctrl.op   = irdla_pkg::POLY_MAC;
                poly_oper      = SAMPLE_BITS'(irdla_pkg::SCALE_FACTOR);
            end
            irdla_pkg::ST_WRITE: ram_we = 1'b1;
            default: ;
        endcase
    end

    irdla_poly #(
        .OPER_W (SAMPLE_BITS)
    ) u_poly (
        .aclk    (aclk),
        .ctrl    (poly_ctrl),
        .operand (poly_oper),
        .acc     (acc)
    );

    // Floor of the scaled value by dropping 8 fraction bits, wrapped to 32 bits.
    assign new_entry = acc[irdla_pkg::FRAC_DROP +: ENTRY_W];

    irdla_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_window (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (win_addr),
        .wdata (new_entry),
        .re    (ram_re),
        .raddr (win_addr),
        .rdata (ram_rdata)
    );

    // A slot not yet written since reset counts as zero.
    assign old_entry = slot_valid_reg[slot_reg] ? ram_rdata : '0;
    assign sum_upd   = sum_reg[ch_reg]
                     + {{(SUM_W-ENTRY_W){new_entry[ENTRY_W-1]}}, new_entry}
                     - {{(SUM_W-ENTRY_W){old_entry[ENTRY_W-1]}}, old_entry};

    // Average: integer part of the sum, divided by the window length through
    // a reciprocal estimate and one correction step.
    assign t_val = sum_reg[ch_reg][SUM_W-1 -: T_W];
    assign q_est = prod_reg[irdla_pkg::RECIP_SHIFT +: T_W];
    assign q_rem = t_val - T_W'(q_est * T_W'(WINDOW));
    assign q_val = (q_rem >= T_W'(WINDOW)) ? q_est + T_W'(1) : q_est;

    // Clamp: upper test first, then the lower test; a negative sum gives zero.
    always_comb begin
        if (sum_reg[ch_reg][SUM_W-1]) begin
            clamp_val = '0;
        end else if (q_val > T_W'(upper_limit_reg)) begin
            clamp_val = upper_value_reg;
        end else if (q_val < T_W'(lower_limit_reg)) begin
            clamp_val = '0;
        end else begin
            clamp_val = q_val[7:0];
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= irdla_pkg::ST_IDLE;
            ch_reg         <= '0;
            term_reg       <= '0;
            slot_reg       <= '0;
            slot_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            case (state_reg)
                irdla_pkg::ST_IDLE: begin
                    ch_reg <= '0;
                end
                irdla_pkg::ST_LOAD: begin
                    term_reg <= 2'd1;
                end
                irdla_pkg::ST_MAC: begin
                    term_reg <= term_reg + 2'd1;
                end
                irdla_pkg::ST_WRITE: begin
                    if (last_ch) begin
                        ch_reg                   <= '0;
                        slot_valid_reg[slot_reg] <= 1'b1;
                        slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ?
                                    '0 : slot_reg + SLOT_W'(1);
                    end else begin
                        ch_reg <= ch_reg + CH_W'(1);
                    end
                end
                irdla_pkg::ST_AVG_FIX: begin
                    ch_reg <= last_ch ? '0 : ch_reg + CH_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Running window sums, cleared at reset with the window's valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (state_reg == irdla_pkg::ST_WRITE) begin
            sum_reg[ch_reg] <= sum_upd;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_limit_reg <= irdla_pkg::UPPER_LIMIT_RST;
            upper_value_reg <= irdla_pkg::UPPER_VALUE_RST;
            lower_limit_reg <= irdla_pkg::LOWER_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                irdla_pkg::CFG_UPPER_LIMIT: upper_limit_reg <= cfg_wdata;
                irdla_pkg::CFG_UPPER_VALUE: upper_value_reg <= cfg_wdata;
                irdla_pkg::CFG_LOWER_LIMIT: lower_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < CHANNELS; i++) begin
                sample_reg[i] <= s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
        if (state_reg == irdla_pkg::ST_AVG_MUL) begin
            prod_reg <= {{RECIP_W{1'b0}}, t_val} * {{T_W{1'b0}}, RECIP};
        end
        if (state_reg == irdla_pkg::ST_AVG_FIX) begin
            res_reg[ch_reg] <= clamp_val;
        end
        if (state_reg == irdla_pkg::ST_OUT && out_free) begin
            for (int i = 0; i < CHANNELS; i++) begin
                m_tdata_reg[i*8 +: 8] <= res_reg[i];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* sv/irdla_ram.sv */
`timescale 1ns / 1ps

// Generic single write port, single read port RAM with registered read.
module irdla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/irdla_poly.sv */
`timescale 1ns / 1ps

// Shared multiply-accumulate unit for Horner evaluation of the cubic.
// The accumulator is kept modulo 2^40, which is all the stored entry needs.
module irdla_poly #(
    parameter int OPER_W = irdla_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         aclk,
    input  irdla_pkg::poly_ctrl_t        ctrl,
    input  logic [OPER_W-1:0]            operand,
    output logic [irdla_pkg::ACC_W-1:0]  acc
);

    localparam int AW = irdla_pkg::ACC_W;
    localparam int CW = irdla_pkg::COEF_W;

    logic [AW-1:0]        acc_reg;
    logic [AW-1:0]        acc_next;
    logic [AW+OPER_W-1:0] prod;
    logic [AW-1:0]        coef_ext;

    // Multiply by the unsigned operand, then add the sign-extended coefficient.
    assign coef_ext = {{(AW-CW){ctrl.coef[CW-1]}}, ctrl.coef};
    assign prod     = {{OPER_W{1'b0}}, acc_reg} * {{AW{1'b0}}, operand};

    always_comb begin
        case (ctrl.op)
            irdla_pkg::POLY_LOAD: acc_next = coef_ext;
            irdla_pkg::POLY_MAC:  acc_next = prod[AW-1:0] + coef_ext;
            default:              acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
